[hw/rtl/sida_pkg.sv]
package sida_pkg;

  localparam int IdW        = 8;
  localparam int PosW       = 5;
  localparam int SkipW      = 9;
  localparam int DistW      = 12;
  localparam int IdCountDef = 256;

  localparam logic [DistW-1:0] DistAllOnes = '1;
  localparam logic [DistW-1:0] DistSat     = 12'd4094;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_PICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef struct packed {
    logic           alloc_en;
    logic           free_en;
    logic [IdW-1:0] free_id;
    logic [IdW-1:0] look_id;
  } map_req_t;

  typedef struct packed {
    logic           alloc_ok;
    logic [IdW-1:0] alloc_id;
    logic           free_ok;
    logic           look_used;
  } map_rsp_t;

  typedef struct packed {
    logic                    en;
    logic                    last;
    logic [IdW-1:0]          pixel_id;
    logic [PosW-1:0]         pixel_row;
    logic [PosW-1:0]         pixel_col;
    logic [PosW-1:0]         win_width;
    logic [PosW-1:0]         win_height;
    logic signed [SkipW-1:0] skip_id;
  } pick_req_t;

endpackage

[hw/rtl/sida_id_map.sv]
module sida_id_map #(
  parameter int ID_COUNT = sida_pkg::IdCountDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sida_pkg::map_req_t req_i,
  output sida_pkg::map_rsp_t rsp_o
);

  localparam int IdxW = $clog2(ID_COUNT);

  logic [ID_COUNT-1:0] used_q, used_d;
  logic                found;
  logic [IdxW-1:0]     alloc_idx;
  logic                free_in_range;
  logic                look_in_range;
  logic                free_hit;

  always_comb begin
    found     = 1'b0;
    alloc_idx = '0;
    for (int i = ID_COUNT - 2; i >= 1; i--) begin
      if (!used_q[i]) begin
        found     = 1'b1;
        alloc_idx = IdxW'(i);
      end
    end
  end

  assign free_in_range = {1'b0, req_i.free_id} < 9'(ID_COUNT);
  assign look_in_range = {1'b0, req_i.look_id} < 9'(ID_COUNT);
  assign free_hit      = free_in_range && used_q[req_i.free_id[IdxW-1:0]];

  assign rsp_o.alloc_ok  = found;
  assign rsp_o.alloc_id  = sida_pkg::IdW'(alloc_idx);
  assign rsp_o.free_ok   = free_hit;
  assign rsp_o.look_used = look_in_range && used_q[req_i.look_id[IdxW-1:0]];

  always_comb begin
    used_d = used_q;
    if (req_i.alloc_en && found) begin
      used_d[alloc_idx] = 1'b1;
    end
    if (req_i.free_en && free_hit) begin
      used_d[req_i.free_id[IdxW-1:0]] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.alloc_en && found |=> used_q[$past(alloc_idx)])
    else $error("allocated entry not marked");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !used_q[0] && !used_q[ID_COUNT-1])
    else $error("reserved entry marked");

endmodule

[hw/rtl/sida_pick.sv]
module sida_pick (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sida_pkg::pick_req_t           req_i,
  input  logic                          used_i,
  output logic [sida_pkg::IdW-1:0]      res_id_o,
  output logic                          res_ok_o
);

  function automatic logic [sida_pkg::DistW-1:0] sq_diff(
    input logic [sida_pkg::PosW-1:0] pos,
    input logic [sida_pkg::PosW-1:0] size
  );
    logic signed [6:0] diff;
    logic [5:0]        mag;
    diff = $signed({1'b0, pos, 1'b0}) - $signed({2'b00, size});
    mag  = diff[6] ? 6'(-diff) : diff[5:0];
    return {6'b0, mag} * {6'b0, mag};
  endfunction

  logic [sida_pkg::DistW-1:0] best_dist_q, best_dist_d;
  logic [sida_pkg::IdW-1:0]   best_id_q, best_id_d;
  logic [sida_pkg::DistW:0]   dist_sum;
  logic [sida_pkg::DistW-1:0] pix_dist;
  logic                       skip_hit;
  logic                       take;
  logic [sida_pkg::DistW-1:0] nb_dist;
  logic [sida_pkg::IdW-1:0]   nb_id;

  assign dist_sum = {1'b0, sq_diff(req_i.pixel_row, req_i.win_height)}
                  + {1'b0, sq_diff(req_i.pixel_col, req_i.win_width)};
  assign pix_dist = (dist_sum > {1'b0, sida_pkg::DistSat}) ? sida_pkg::DistSat
                                                           : dist_sum[sida_pkg::DistW-1:0];
  assign skip_hit = !req_i.skip_id[sida_pkg::SkipW-1]
                 && (req_i.skip_id[sida_pkg::IdW-1:0] == req_i.pixel_id);
  assign take     = (req_i.pixel_id != '0) && used_i && !skip_hit && (pix_dist < best_dist_q);
  assign nb_dist  = take ? pix_dist : best_dist_q;
  assign nb_id    = take ? req_i.pixel_id : best_id_q;

  assign res_id_o = nb_id;
  assign res_ok_o = nb_id != '0;

  always_comb begin
    best_dist_d = best_dist_q;
    best_id_d   = best_id_q;
    if (req_i.en) begin
      if (req_i.last) begin
        best_dist_d = sida_pkg::DistAllOnes;
        best_id_d   = '0;
      end else begin
        best_dist_d = nb_dist;
        best_id_d   = nb_id;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_dist_q <= sida_pkg::DistAllOnes;
      best_id_q   <= '0;
    end else begin
      best_dist_q <= best_dist_d;
      best_id_q   <= best_id_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.en && req_i.last |=> best_dist_q == sida_pkg::DistAllOnes && best_id_q == '0)
    else $error("best not cleared after last pixel");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (best_id_q == '0) == (best_dist_q == sida_pkg::DistAllOnes))
    else $error("best id and distance disagree");

endmodule

[hw/rtl/stencil_id_alloc_and_nearest_pick_unit.sv]
// Object ID allocator with nearest-to-centre pick.
// Input stream: tuser carries the operation (allocate, free, pick pixel),
// tlast marks the final pixel of a pick window, tdata carries the operands.
// Output stream: tdata carries the allocated or picked ID, tuser[0] the ok flag.
// Allocate and free give one result beat each; pick pixels give a result only
// on the final pixel of the window, other pick beats and unknown operations
// give none.
// An item sits in the input register, then its result in the result register.
// Throughput: one beat per cycle unless the receiver stalls, set by the single
// pass through the ID bitmap priority encoder and the squared-distance compare.
// A new beat is taken while a finished result still waits at the output.
// When the receiver stalls, the result register holds and the input register
// holds one beat; beats that give no result still drain.
// Reset clears the whole ID map at once and empties the pick state; no
// clearing pass is needed.
module stencil_id_alloc_and_nearest_pick_unit #(
  parameter int ID_COUNT = sida_pkg::IdCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // release_id[7:0], pixel_id[15:8], pixel_row[20:16], pixel_col[25:21],
  // win_width[30:26], win_height[35:31], skip_id[44:36], zero[47:45]
  input  logic [47:0] s_axis_tdata_i,
  // operation[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  // last_pixel
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // result_id[7:0]
  output logic [7:0]  m_axis_tdata_o,
  // ok[0]
  output logic [0:0]  m_axis_tuser_o
);

  logic                in_valid_q, in_valid_d;
  sida_pkg::op_e       op_q;
  logic [47:0]         data_q;
  logic                last_q;
  logic                accept_in;
  logic                produces;
  logic                advance;
  logic                out_valid_q, out_valid_d;
  logic [7:0]          out_id_q;
  logic                out_ok_q;
  logic [7:0]          res_id;
  logic                res_ok;
  logic [7:0]          pick_id;
  logic                pick_ok;
  sida_pkg::map_req_t  map_req;
  sida_pkg::map_rsp_t  map_rsp;
  sida_pkg::pick_req_t pick_req;

  assign accept_in = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    unique case (op_q)
      sida_pkg::OP_ALLOC: produces = 1'b1;
      sida_pkg::OP_FREE:  produces = 1'b1;
      sida_pkg::OP_PICK:  produces = last_q;
      default:            produces = 1'b0;
    endcase
  end

  assign advance         = in_valid_q && (!produces || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept_in) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      op_q   <= sida_pkg::op_e'(s_axis_tuser_i);
      data_q <= s_axis_tdata_i;
      last_q <= s_axis_tlast_i;
    end
  end

  assign map_req.alloc_en = advance && (op_q == sida_pkg::OP_ALLOC);
  assign map_req.free_en  = advance && (op_q == sida_pkg::OP_FREE);
  assign map_req.free_id  = data_q[7:0];
  assign map_req.look_id  = data_q[15:8];

  assign pick_req.en         = advance && (op_q == sida_pkg::OP_PICK);
  assign pick_req.last       = last_q;
  assign pick_req.pixel_id   = data_q[15:8];
  assign pick_req.pixel_row  = data_q[20:16];
  assign pick_req.pixel_col  = data_q[25:21];
  assign pick_req.win_width  = data_q[30:26];
  assign pick_req.win_height = data_q[35:31];
  assign pick_req.skip_id    = $signed(data_q[44:36]);

  sida_id_map #(
    .ID_COUNT(ID_COUNT)
  ) u_id_map (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (map_req),
    .rsp_o  (map_rsp)
  );

  sida_pick u_pick (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (pick_req),
    .used_i   (map_rsp.look_used),
    .res_id_o (pick_id),
    .res_ok_o (pick_ok)
  );

  always_comb begin
    unique case (op_q)
      sida_pkg::OP_ALLOC: begin
        res_id = map_rsp.alloc_ok ? map_rsp.alloc_id : '0;
        res_ok = map_rsp.alloc_ok;
      end
      sida_pkg::OP_FREE: begin
        res_id = '0;
        res_ok = map_rsp.free_ok;
      end
      sida_pkg::OP_PICK: begin
        res_id = pick_id;
        res_ok = pick_ok;
      end
      default: begin
        res_id = '0;
        res_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && produces) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && produces) begin
      out_id_q <= res_id;
      out_ok_q <= res_ok;
    end
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = out_id_q;
  assign m_axis_tuser_o[0] = out_ok_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(advance && produces))
    else $error("result beat without a finished item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready_i && in_valid_q && produces |-> !s_axis_tready_o)
    else $error("input taken while result stage blocked");

endmodule

[tb/tb_stencil_id_alloc_and_nearest_pick_unit.sv]
module tb_stencil_id_alloc_and_nearest_pick_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import sida_pkg::*;

  localparam logic [8:0] NoSkip = 9'h1FF;
  localparam int HoldCycles = 150;

  typedef struct {
    op_e        op;
    logic [7:0] release_id;
    logic [7:0] pixel_id;
    logic [4:0] row;
    logic [4:0] col;
    logic [4:0] ww;
    logic [4:0] wh;
    logic [8:0] skip;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic [7:0] id;
    logic       ok;
  } id_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = OP_NONE;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;
  logic [0:0]  m_axis_tuser_o;

  beat_t      beat_q[$];
  beat_t      cur_beat;
  id_result_t due_results[$];

  bit          id_used [IdCountDef];
  logic [11:0] near_dist = DistAllOnes;
  logic [7:0]  near_id = '0;

  logic in_fire = 1'b0;
  int   tx_wait = 0;
  bit   tx_calm = 1'b0;
  int   rx_wait = 0;
  bit   rx_calm = 1'b0;
  int   hold_left = 0;
  int   next_hold = 350;

  int n_items = 0;
  int beat_total = 0;
  int n_in = 0;
  int n_out = 0;
  int n_err = 0;
  int n_full = 0;
  int op_seen [4] = '{default: 0};

  stencil_id_alloc_and_nearest_pick_unit #(
    .ID_COUNT(IdCountDef)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .s_axis_tlast_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o
  );

  always #5ns clk_i = ~clk_i;

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 30);
  endfunction

  function automatic int sq_offset(input logic [4:0] pos, input logic [4:0] size);
    int diff;
    diff = 2 * int'(pos) - int'(size);
    return diff * diff;
  endfunction

  task automatic predict_id_result(input beat_t b);
    id_result_t r;
    int         d;
    bit         hit;
    r = '0;
    hit = 1'b0;
    case (b.op)
      OP_ALLOC: begin
        for (int i = 1; i < IdCountDef - 1; i++) begin
          if (!hit && !id_used[i]) begin
            id_used[i] = 1'b1;
            r.id = 8'(i);
            r.ok = 1'b1;
            hit = 1'b1;
          end
        end
        if (!hit) n_full++;
        due_results.push_back(r);
      end
      OP_FREE: begin
        r.ok = id_used[b.release_id];
        id_used[b.release_id] = 1'b0;
        due_results.push_back(r);
      end
      OP_PICK: begin
        d = sq_offset(b.row, b.wh) + sq_offset(b.col, b.ww);
        if (d > int'(DistSat)) d = int'(DistSat);
        if (b.pixel_id != 0 && id_used[b.pixel_id] &&
            !(!b.skip[8] && b.skip[7:0] == b.pixel_id) && d < int'(near_dist)) begin
          near_dist = 12'(d);
          near_id = b.pixel_id;
        end
        if (b.last) begin
          r.id = near_id;
          r.ok = (near_id != 0);
          due_results.push_back(r);
          near_dist = DistAllOnes;
          near_id = '0;
        end
      end
      default: ;
    endcase
  endtask

  function automatic beat_t any_beat();
    beat_t b;
    b.op = op_e'($urandom_range(0, 3));
    b.release_id = 8'($urandom);
    b.pixel_id = 8'($urandom);
    b.row = 5'($urandom);
    b.col = 5'($urandom);
    b.ww = 5'($urandom);
    b.wh = 5'($urandom);
    b.skip = 9'($urandom);
    b.last = 1'($urandom);
    return b;
  endfunction

  function automatic logic [7:0] likely_id();
    if ($urandom_range(0, 3) == 0) return 8'($urandom);
    return 8'($urandom_range(0, 40));
  endfunction

  task automatic push_beat(input beat_t b);
    beat_q.push_back(b);
    beat_total++;
    if (b.op != OP_NONE) n_items++;
  endtask

  task automatic push_alloc();
    beat_t b;
    b = any_beat();
    b.op = OP_ALLOC;
    push_beat(b);
  endtask

  task automatic push_free(input logic [7:0] id);
    beat_t b;
    b = any_beat();
    b.op = OP_FREE;
    b.release_id = id;
    push_beat(b);
  endtask

  task automatic push_pixel(input logic [7:0] id, input int row, input int col,
                            input int ww, input int wh, input logic [8:0] skip,
                            input bit last);
    beat_t b;
    b = any_beat();
    b.op = OP_PICK;
    b.pixel_id = id;
    b.row = 5'(row);
    b.col = 5'(col);
    b.ww = 5'(ww);
    b.wh = 5'(wh);
    b.skip = skip;
    b.last = last;
    push_beat(b);
  endtask

  task automatic push_window();
    int         ww;
    int         wh;
    int         n;
    int         row;
    int         col;
    logic [8:0] skip;
    case ($urandom_range(0, 9))
      0: begin
        ww = $urandom_range(0, 31);
        wh = $urandom_range(0, 31);
      end
      1: begin
        ww = $urandom_range(7, 31);
        wh = $urandom_range(7, 31);
      end
      default: begin
        ww = $urandom_range(1, 6);
        wh = $urandom_range(1, 6);
      end
    endcase
    case ($urandom_range(0, 3))
      0: skip = NoSkip;
      1: skip = {1'b1, 8'($urandom)};
      default: skip = {1'b0, likely_id()};
    endcase
    n = ww * wh;
    if (n != 0 && n <= 36) begin
      for (int k = 0; k < n; k++)
        push_pixel(likely_id(), k / ww, k % ww, ww, wh, skip, k == n - 1);
    end else begin
      n = $urandom_range(1, 12);
      for (int k = 0; k < n; k++) begin
        row = (wh == 0) ? $urandom_range(0, 31) : $urandom_range(0, wh - 1);
        col = (ww == 0) ? $urandom_range(0, 31) : $urandom_range(0, ww - 1);
        push_pixel(likely_id(), row, col, ww, wh, skip, k == n - 1);
      end
    end
  endtask

  // hold the beat until taken, then gap or advance
  always @(negedge clk_i) begin : drive
    beat_t b;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else if (!s_axis_tvalid_i || in_fire) begin
      if (tx_wait > 0) begin
        tx_wait <= tx_wait - 1;
        s_axis_tvalid_i <= 1'b0;
      end else if (beat_q.size() != 0) begin
        b = beat_q.pop_front();
        cur_beat <= b;
        s_axis_tdata_i <= {3'b000, b.skip, b.wh, b.ww, b.col, b.row, b.pixel_id,
                           b.release_id};
        s_axis_tuser_i <= b.op;
        s_axis_tlast_i <= b.last;
        s_axis_tvalid_i <= 1'b1;
        if ($urandom_range(0, 63) == 0) tx_calm <= !tx_calm;
        tx_wait <= (tx_calm || hold_left > 0) ? 0 : draw_gap();
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : receive
    if (rst_ni && n_in >= next_hold) begin
      hold_left <= HoldCycles;
      next_hold <= next_hold + 750;
      m_axis_tready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      if ($urandom_range(0, 99) == 0) rx_calm <= !rx_calm;
      if (!rx_calm && $urandom_range(0, 3) == 0) begin
        rx_wait <= draw_gap();
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check
    id_result_t want;
    if (rst_ni) begin
      in_fire <= s_axis_tvalid_i && s_axis_tready_o;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        n_out++;
        if (due_results.size() == 0) begin
          $error("result beat with nothing due: result_id %0d ok %0b",
                 m_axis_tdata_o, m_axis_tuser_o[0]);
          n_err++;
        end else begin
          want = due_results.pop_front();
          if (m_axis_tdata_o !== want.id) begin
            $error("result_id: expected %0d, got %0d", want.id, m_axis_tdata_o);
            n_err++;
          end
          if (m_axis_tuser_o[0] !== want.ok) begin
            $error("ok: expected %0b, got %0b", want.ok, m_axis_tuser_o[0]);
            n_err++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_id_result(cur_beat);
        op_seen[cur_beat.op]++;
        n_in++;
      end
    end
  end

  initial begin : stimulus
    beat_t b;
    bit    filled;
    int    r;
    filled = 1'b0;

    push_alloc();
    push_alloc();
    push_alloc();
    push_free(8'd0);
    push_free(8'd2);
    push_free(8'd2);
    push_free(8'd255);
    push_alloc();
    b = any_beat();
    b.op = OP_NONE;
    push_beat(b);
    push_pixel(8'd0, 1, 1, 3, 3, NoSkip, 1'b0);
    push_pixel(8'd200, 1, 1, 3, 3, NoSkip, 1'b0);
    push_pixel(8'd3, 1, 1, 3, 3, 9'd3, 1'b0);
    push_pixel(8'd1, 0, 0, 3, 3, NoSkip, 1'b0);
    push_pixel(8'd2, 2, 2, 3, 3, NoSkip, 1'b0);
    push_pixel(8'd3, 1, 0, 3, 3, 9'h103, 1'b1);
    push_pixel(8'd0, 0, 0, 1, 1, NoSkip, 1'b1);
    push_pixel(8'd1, 31, 31, 0, 0, NoSkip, 1'b0);
    push_pixel(8'd255, 0, 0, 31, 31, 9'h0FF, 1'b1);
    push_pixel(8'd2, 31, 31, 31, 31, 9'h100, 1'b1);

    while (n_items < 1450) begin
      if (!filled && n_items >= 400) begin
        filled = 1'b1;
        repeat (256) push_alloc();
        repeat (3) push_window();
        repeat (180) push_free(8'($urandom_range(1, 254)));
      end
      r = $urandom_range(0, 99);
      if (r < 40) begin
        push_window();
      end else if (r < 70) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 1) == 0) push_alloc();
          else push_free(likely_id());
        end
      end else if (r < 85) begin
        b = any_beat();
        b.op = OP_PICK;
        b.last = ($urandom_range(0, 3) == 0);
        push_beat(b);
      end else if (r < 90) begin
        b = any_beat();
        b.op = OP_NONE;
        push_beat(b);
      end else begin
        push_beat(any_beat());
      end
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (n_in == beat_total);
    wait (due_results.size() == 0);
    repeat (16) @(posedge clk_i);

    $display("covered %0d beats: %0d allocate, %0d free, %0d pick pixel, %0d ignored",
             n_in, op_seen[OP_ALLOC], op_seen[OP_FREE], op_seen[OP_PICK], op_seen[OP_NONE]);
    $display("checked %0d result beats, %0d of them allocate with the map full",
             n_out, n_full);
    if (n_err == 0) begin
      $display("PASS stencil_id_alloc_and_nearest_pick_unit");
    end else begin
      $display("FAIL stencil_id_alloc_and_nearest_pick_unit");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("FAIL stencil_id_alloc_and_nearest_pick_unit");
    $finish;
  end

endmodule

[files.f]
hw/rtl/sida_pkg.sv
hw/rtl/sida_id_map.sv
hw/rtl/sida_pick.sv
hw/rtl/stencil_id_alloc_and_nearest_pick_unit.sv
tb/tb_stencil_id_alloc_and_nearest_pick_unit.sv
